>>> hw/rtl/scl_pkg.sv
// Shared constants and types for the signal curve length block.
// No dependencies; compiled first.
`default_nettype none

package scl_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  // Row total: unsigned Q22.8, saturating.
  localparam int TOTAL_W = 30;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // 1.0 in the Q.16 radicand.
  localparam int ONE_Q16 = 65536;

  // Commands from the sequencer to the accumulator.
  typedef struct packed {
    logic add;   // add the finished root to the row total
    logic emit;  // move the row total to the output register and clear it
  } acc_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/scl_if.sv
// Valid/ready channel interfaces for the signal curve length block.
// Depends on scl_pkg.
`default_nettype none

interface scl_in_if #(
  parameter int SampleBits = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;
  logic                         row_end;

  modport source (output valid, output sample, output row_end, input ready);
  modport sink   (input valid, input sample, input row_end, output ready);
endinterface

interface scl_out_if ();
  import scl_pkg::*;

  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] length_sum;

  modport source (output valid, output length_sum, input ready);
  modport sink   (input valid, input length_sum, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/scl_isqrt.sv
// Squares a magnitude, adds 1.0 and takes the floor square root two radicand
// bits per cycle. Depends on scl_pkg.
`default_nettype none

module scl_isqrt #(
  parameter int MagW = 17
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [MagW-1:0] mag,
  output logic            done,
  output logic [MagW-1:0] root
);
  import scl_pkg::*;

  localparam int RadW = 2 * MagW;
  localparam int RemW = MagW + 2;
  localparam int ShW  = MagW + 4;
  localparam int CntW = $clog2(MagW);
  localparam logic [CntW-1:0] CntLast = CntW'(MagW - 1);

  logic [RadW-1:0] sq;
  logic [RadW-1:0] rad;
  logic [RemW-1:0] rem;
  logic [CntW-1:0] cnt;
  logic            run;

  logic [ShW-1:0]  rem_sh;
  logic [ShW-1:0]  trial;
  logic [ShW-1:0]  rem_sub;
  logic            fits;

  assign sq = RadW'(mag) * RadW'(mag);

  // One restoring step: bring down the next radicand digit, try root*4+1.
  assign rem_sh  = {rem, rad[RadW-1 -: 2]};
  assign trial   = {2'b00, root, 2'b01};
  assign rem_sub = rem_sh - trial;
  assign fits    = rem_sh >= trial;
  assign done    = run && (cnt == CntLast);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= '0;
    end else if (run) begin
      run <= !done;
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= sq + RadW'(ONE_Q16);
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      rad  <= {rad[RadW-3:0], 2'b00};
      rem  <= fits ? rem_sub[RemW-1:0] : rem_sh[RemW-1:0];
      root <= {root[MagW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/scl_acc.sv
// Saturating row total and the output register of the result channel.
// Depends on scl_pkg and scl_out_if.
`default_nettype none

module scl_acc #(
  parameter int RootW = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  scl_pkg::acc_ctrl_t ctrl,
  input  logic [RootW-1:0]  term,
  output logic              room,
  scl_out_if.source         length_ch
);
  import scl_pkg::*;

  localparam int SumW = ((RootW > TOTAL_W) ? RootW : TOTAL_W) + 1;

  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;
  logic [SumW-1:0]    sum;
  logic               out_valid;

  assign sum        = SumW'(total) + SumW'(term);
  assign total_next = (sum > SumW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];

  // Output register is free when empty or being drained this cycle.
  assign room            = !out_valid || length_ch.ready;
  assign length_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (ctrl.emit) begin
      total <= '0;
    end else if (ctrl.add) begin
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (length_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      length_ch.length_sum <= total;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/signal_curve_length.sv
// Channel      Dir   Payload                          Transfer
// sample_ch    sink  sample (signed Q8.8), row_end    valid & ready
// length_ch    src   length_sum (30b unsigned Q22.8)  valid & ready
//
// A sample with a predecessor in its row goes through accept, square,
// SAMPLE_BITS+1 root digit steps in the serial root unit, and add. The
// first sample of a row is only stored unless it also ends the row. A row
// end passes last through the emit state, which loads the output register.
// Synchronous reset clears the sequencer, row state and output valid.
// A held result does not block input; only a second row end waits for it.
// Depends on scl_pkg, scl_if, scl_isqrt, scl_acc.
`default_nettype none

module signal_curve_length #(
  parameter int SAMPLE_BITS = scl_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  scl_in_if.sink     sample_ch,
  scl_out_if.source  length_ch
);
  import scl_pkg::*;

  localparam int MagW = SAMPLE_BITS + 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SQUARE = 5'b00010,
    ST_ROOT   = 5'b00100,
    ST_ACCUM  = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [SAMPLE_BITS-1:0] prior_sample;
  logic                   prior_valid;
  logic                   last;
  logic [MagW-1:0]        mag;

  logic [MagW-1:0]        diff;
  logic [MagW-1:0]        diff_abs;
  logic                   in_fire;
  logic                   sq_start;
  logic                   sq_done;
  logic [MagW-1:0]        root;
  logic                   room;
  acc_ctrl_t              acc_ctrl;

  assign sample_ch.ready = (state == ST_IDLE);
  assign in_fire         = sample_ch.valid && sample_ch.ready;

  // Exact difference, one bit wider than a sample.
  assign diff     = {sample_ch.sample[SAMPLE_BITS-1], sample_ch.sample}
                  - {prior_sample[SAMPLE_BITS-1], prior_sample};
  assign diff_abs = diff[MagW-1] ? (~diff + 1'b1) : diff;

  assign sq_start      = (state == ST_SQUARE);
  assign acc_ctrl.add  = (state == ST_ACCUM);
  assign acc_ctrl.emit = (state == ST_EMIT) && room;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (prior_valid) begin
            state_next = ST_SQUARE;
          end else if (sample_ch.row_end) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_SQUARE: state_next = ST_ROOT;
      ST_ROOT: begin
        if (sq_done) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM:  state_next = last ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (room) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      prior_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        prior_valid <= !sample_ch.row_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_sample <= '0;
    end else if (in_fire) begin
      prior_sample <= sample_ch.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      last <= sample_ch.row_end;
      mag  <= diff_abs;
    end
  end

  scl_isqrt #(
    .MagW (MagW)
  ) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .mag   (mag),
    .done  (sq_done),
    .root  (root)
  );

  scl_acc #(
    .RootW (MagW)
  ) u_acc (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (acc_ctrl),
    .term      (root),
    .room      (room),
    .length_ch (length_ch)
  );

  // Root unit finishes only while the sequencer waits for it.
  a_done_in_root: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == ST_ROOT))
    else $error("root unit finished outside the root state");

  // A row end held back by a full output register keeps waiting.
  a_emit_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && length_ch.valid && !length_ch.ready |=> (state == ST_EMIT))
    else $error("row end left the emit state while the output was full");

  // Loading a result always shows up on the output channel.
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    acc_ctrl.emit |=> length_ch.valid)
    else $error("emitted row total not presented");

  // A row end starts a fresh row.
  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    in_fire && sample_ch.row_end |=> !prior_valid)
    else $error("row state not cleared after row end");

endmodule

`default_nettype wire
